// ===== rtl/core/hcpd_pkg.sv =====
// Shared types, colour codes and register indexes for the hi-res colour pixel doubler.
`default_nettype none

package hcpd_pkg;

    typedef logic [2:0] t_color;
    typedef logic [7:0] t_byte;
    typedef logic [8:0] t_drow;
    typedef logic [6:0] t_col;
    typedef logic [7:0] t_srow;
    typedef logic [0:0] t_cfg_index;
    typedef logic [7:0] t_cfg_data;

    localparam t_color ColBlack  = 3'd0;
    localparam t_color ColViolet = 3'd1;
    localparam t_color ColGreen  = 3'd2;
    localparam t_color ColBlue   = 3'd3;
    localparam t_color ColOrange = 3'd4;
    localparam t_color ColWhite  = 3'd5;

    localparam t_cfg_index CfgSourceWidthBytes = 1'b0;
    localparam t_cfg_index CfgSourceRows       = 1'b1;

    localparam int         DotsPerByte = 7;
    localparam logic [2:0] LastDotPos  = 3'(DotsPerByte - 1);

    // One finished byte, from which both emissions are formed.
    typedef struct packed {
        t_byte byte_value;
        t_srow source_row;
        t_col  byte_col;
        logic  last;
    } t_pair;

    function automatic logic lit_left(input t_color c);
        return (c == ColViolet) || (c == ColBlue) || (c == ColWhite);
    endfunction

    function automatic logic lit_right(input t_color c);
        return (c == ColGreen) || (c == ColOrange) || (c == ColWhite);
    endfunction

    function automatic logic is_palette(input t_color c);
        return (c == ColBlue) || (c == ColOrange);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hcpd_in_if.sv =====
// Input channel carrying one source colour cell per item.
`default_nettype none

interface hcpd_in_if;
    logic                 valid;
    logic                 ready;
    hcpd_pkg::t_color     color;

    modport source (output valid, output color, input ready);
    modport sink   (input valid, input color, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hcpd_out_if.sv =====
// Output channel carrying one packed destination byte per item.
`default_nettype none

interface hcpd_out_if;
    logic                 valid;
    logic                 ready;
    hcpd_pkg::t_byte      byte_value;
    hcpd_pkg::t_drow      dest_row;
    hcpd_pkg::t_col       dest_byte_col;
    logic                 last;

    modport source (output valid, output byte_value, output dest_row,
                    output dest_byte_col, output last, input ready);
    modport sink   (input valid, input byte_value, input dest_row,
                    input dest_byte_col, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hcpd_cfg_if.sv =====
// Configuration write channel: register index and write data.
`default_nettype none

interface hcpd_cfg_if;
    logic                 valid;
    logic                 ready;
    hcpd_pkg::t_cfg_index index;
    hcpd_pkg::t_cfg_data  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hcpd_packer.sv =====
// Dot packer: turns each cell into two dots and reports a finished byte.
`default_nettype none

module hcpd_packer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  hcpd_pkg::t_color  i_color,
    input  logic [6:0]        i_width,
    input  logic [8:0]        i_rows,
    output logic              o_emit,
    output hcpd_pkg::t_pair   o_pair
);
    import hcpd_pkg::*;

    logic [2:0] r_dot_pos, n_dot_pos;
    logic [6:0] r_acc, n_acc;
    logic       r_flag, n_flag;
    t_col       r_byte_col, n_byte_col;
    t_srow      r_src_row, n_src_row;

    logic       lit_l, lit_r, pal;
    logic [6:0] acc_a, acc_b, acc_c;
    logic       flag_a, flag_b, flag_c;
    logic       fin_a, fin_b;
    logic [2:0] pos_b;
    logic [7:0] col_inc;
    logic [8:0] row_inc;
    logic       row_end, shape_end;

    always_comb begin
        lit_l = lit_left(i_color);
        lit_r = lit_right(i_color);
        pal   = is_palette(i_color);

        // Left dot.
        acc_a  = r_acc | (lit_l ? (7'd1 << r_dot_pos) : 7'd0);
        flag_a = r_flag | (lit_l & pal);
        fin_a  = (r_dot_pos == LastDotPos);

        // Right dot, starting a fresh byte if the left dot closed one.
        pos_b  = fin_a ? 3'd0 : (r_dot_pos + 3'd1);
        acc_b  = fin_a ? 7'd0 : acc_a;
        flag_b = fin_a ? 1'b0 : flag_a;
        acc_c  = acc_b | (lit_r ? (7'd1 << pos_b) : 7'd0);
        flag_c = flag_b | (lit_r & pal);
        fin_b  = (pos_b == LastDotPos);

        col_inc   = {1'b0, r_byte_col} + 8'd1;
        row_inc   = {1'b0, r_src_row} + 9'd1;
        row_end   = (col_inc >= {i_width, 1'b0});
        shape_end = row_end && (row_inc >= i_rows);

        o_emit            = fin_a | fin_b;
        o_pair.byte_value = fin_a ? {flag_a, acc_a} : {flag_c, acc_c};
        o_pair.source_row = r_src_row;
        o_pair.byte_col   = r_byte_col;
        o_pair.last       = shape_end;

        n_acc      = acc_c;
        n_flag     = flag_c;
        n_dot_pos  = pos_b + 3'd1;
        n_byte_col = r_byte_col;
        n_src_row  = r_src_row;
        if (o_emit) begin
            // A row that ends on a left dot drops the cell's right dot.
            if (fin_b || row_end) begin
                n_acc     = 7'd0;
                n_flag    = 1'b0;
                n_dot_pos = 3'd0;
            end
            if (row_end) begin
                n_byte_col = '0;
                n_src_row  = shape_end ? t_srow'(0) : row_inc[7:0];
            end else begin
                n_byte_col = col_inc[6:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_pos  <= 3'd0;
            r_acc      <= 7'd0;
            r_flag     <= 1'b0;
            r_byte_col <= '0;
            r_src_row  <= '0;
        end else if (i_accept) begin
            r_dot_pos  <= n_dot_pos;
            r_acc      <= n_acc;
            r_flag     <= n_flag;
            r_byte_col <= n_byte_col;
            r_src_row  <= n_src_row;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/hires_color_pixel_doubler.sv =====
// Top level of the hi-res colour pixel doubler: configuration, packer and output queue.
`default_nettype none

// Takes one colour cell per clock while the output queue has room and packs
// its two doubled dots into seven-dot bytes; every finished byte leaves as
// two items, one per doubled row, the second of the final byte of the shape
// carrying last. A cell offered while the queue has room is accepted in the
// same cycle, and the dots it adds are folded into the packer state at that
// edge. Finished bytes wait in a two-entry queue that drains one item per
// cycle while the output is ready; as bytes finish at most every three cells,
// the input takes an item every cycle and stalls only when the output side
// holds back. Configuration writes are taken at any time and are always ready.
module hires_color_pixel_doubler #(
    parameter int MAX_WIDTH_BYTES = 40,
    parameter int MAX_ROWS        = 192
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hcpd_in_if.sink     i_pix,
    hcpd_cfg_if.sink    i_cfg,
    hcpd_out_if.source  o_byte
);
    import hcpd_pkg::*;

    localparam logic [6:0] WidthMax   = 7'(MAX_WIDTH_BYTES);
    localparam logic [8:0] RowsMax    = 9'(MAX_ROWS);
    localparam logic [6:0] WidthReset = 7'((40 > MAX_WIDTH_BYTES) ? MAX_WIDTH_BYTES : 40);
    localparam logic [8:0] RowsReset  = 9'((192 > MAX_ROWS) ? MAX_ROWS : 192);

    logic [6:0] r_width;
    logic [8:0] r_rows;
    logic [6:0] cfg_width;
    logic [8:0] cfg_rows;

    t_pair      r_q [2];
    logic       r_wptr, r_rptr, r_beat;
    logic [1:0] r_count;

    logic       accept, emit, push, pop;
    t_pair      pair, head;

    // Zero acts as one and oversize values saturate; the width uses only data bits 5:0.
    always_comb begin
        if (i_cfg.data[5:0] == 6'd0) begin
            cfg_width = 7'd1;
        end else if ({1'b0, i_cfg.data[5:0]} > WidthMax) begin
            cfg_width = WidthMax;
        end else begin
            cfg_width = {1'b0, i_cfg.data[5:0]};
        end
        if (i_cfg.data == 8'd0) begin
            cfg_rows = 9'd1;
        end else if ({1'b0, i_cfg.data} > RowsMax) begin
            cfg_rows = RowsMax;
        end else begin
            cfg_rows = {1'b0, i_cfg.data};
        end
    end

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WidthReset;
            r_rows  <= RowsReset;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CfgSourceWidthBytes: r_width <= cfg_width;
                CfgSourceRows:       r_rows  <= cfg_rows;
                default:             r_width <= r_width;
            endcase
        end
    end

    assign i_pix.ready = (r_count != 2'd2);
    assign accept      = i_pix.valid && i_pix.ready;

    hcpd_packer u_packer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_color  (i_pix.color),
        .i_width  (r_width),
        .i_rows   (r_rows),
        .o_emit   (emit),
        .o_pair   (pair)
    );

    assign push = accept && emit;
    assign pop  = o_byte.valid && o_byte.ready && r_beat;
    assign head = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_beat  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            if (o_byte.valid && o_byte.ready) begin
                r_beat <= ~r_beat;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

    // The first item of a byte goes to the even row, the second to the odd row.
    assign o_byte.valid         = (r_count != 2'd0);
    assign o_byte.byte_value    = head.byte_value;
    assign o_byte.dest_row      = {head.source_row, r_beat};
    assign o_byte.dest_byte_col = head.byte_col;
    assign o_byte.last          = head.last && r_beat;

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_count != 2'd2))
        else $error("byte pushed into a full output queue");

    a_push_shows_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> o_byte.valid)
        else $error("finished byte not presented on the output");

    a_second_item_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_byte.valid && o_byte.ready && !r_beat) |=>
            (o_byte.valid && r_beat && $stable(o_byte.dest_byte_col)))
        else $error("second item of a byte missing or altered");

endmodule

`default_nettype wire
